[hdl/hhi_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, defaults, status codes and controller states for the hopscotch insert block.
package hhi_pkg;

   // Parameter defaults
   localparam int LOG2_BUCKETS_DEF = 10;
   localparam int NEIGHBORHOOD_DEF = 15;

   // Fixed field widths of the request and response words
   localparam int HASH_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 10;
   localparam int DIST_W   = 4;
   localparam int OCC_W    = 11;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_MOVE = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_CHECK,
      S_SCAN,
      S_SETFREE,
      S_CLRMOVE,
      S_FINAL,
      S_HOMEUPD,
      S_DONE
   } state_type;

endpackage

[hdl/hhi_bucket_ram.sv]
`timescale 1ns / 1ps
// Bucket word memory: one write port, one registered read port with write forwarding.
module hhi_bucket_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [(1 << ADDR_W)];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, new data on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/hhi_ctrl.sv]
`timescale 1ns / 1ps
// Insert sequencer: clear sweep, probe, displacement scan, bucket updates and response register.
module hhi_ctrl
   import hhi_pkg::*;
#(
   parameter int LOG2_BUCKETS = LOG2_BUCKETS_DEF,
   parameter int NEIGHBORHOOD = NEIGHBORHOOD_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [HASH_W-1:0]          req_hash_value,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]          rsp_slot_index,
   output logic [DIST_W-1:0]          rsp_hop_distance,
   output logic [OCC_W-1:0]           rsp_occupancy,
   // bucket memory
   output logic                       mem_we,
   output logic [LOG2_BUCKETS-1:0]    mem_waddr,
   output logic [NEIGHBORHOOD:0]      mem_wdata,
   output logic [LOG2_BUCKETS-1:0]    mem_raddr,
   input  logic [NEIGHBORHOOD:0]      mem_rdata
);

   localparam int IDX_W  = LOG2_BUCKETS;
   localparam int WORD_W = NEIGHBORHOOD + 1;
   localparam int CNT_W  = LOG2_BUCKETS + 1;
   localparam int SD_W   = $clog2(NEIGHBORHOOD);
   localparam int HOP_W  = $clog2(NEIGHBORHOOD + 1);

   localparam logic [WORD_W-1:0] OCC_MASK  = WORD_W'(1) << NEIGHBORHOOD;
   localparam logic [CNT_W-1:0]  TABLE_CNT = CNT_W'(1) << IDX_W;
   localparam logic [IDX_W-1:0]  LAST_IDX  = {IDX_W{1'b1}};

   // lowest set hop bit, NEIGHBORHOOD when none
   function automatic logic [HOP_W-1:0] lowest_hop(input logic [WORD_W-1:0] w);
      logic [HOP_W-1:0] h;
      h = HOP_W'(NEIGHBORHOOD);
      for (int d = NEIGHBORHOOD - 1; d >= 0; d--) begin
         if (w[d]) begin
            h = HOP_W'(d);
         end
      end
      return h;
   endfunction

   state_type          state_ff,     state_in;
   logic [IDX_W-1:0]   clr_addr_ff,  clr_addr_in;
   logic [IDX_W-1:0]   home_ff,      home_in;
   logic [IDX_W-1:0]   free_idx_ff,  free_idx_in;
   logic [IDX_W-1:0]   free_span_ff, free_span_in;
   logic [WORD_W-1:0]  free_word_ff, free_word_in;
   logic [IDX_W-1:0]   scan_idx_ff,  scan_idx_in;
   logic [SD_W-1:0]    scan_dist_ff, scan_dist_in;
   logic [IDX_W-1:0]   move_idx_ff,  move_idx_in;
   logic [SD_W-1:0]    move_span_ff, move_span_in;
   logic               hop_zero_ff,  hop_zero_in;
   logic [WORD_W-1:0]  aux_word_ff,  aux_word_in;
   logic [CNT_W-1:0]   count_ff,     count_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff,  rsp_slot_in;
   logic [DIST_W-1:0]  rsp_dist_ff,  rsp_dist_in;
   logic [OCC_W-1:0]   rsp_occ_ff,   rsp_occ_in;

   logic [HOP_W-1:0]   hop;
   logic               found;
   logic [WORD_W-1:0]  scan_new;

   // scan evaluation on the word just read
   assign hop   = lowest_hop(mem_rdata);
   assign found = hop < HOP_W'(scan_dist_ff);

   always_comb begin
      scan_new = (mem_rdata & ~(WORD_W'(1) << hop)) | (WORD_W'(1) << scan_dist_ff);
      if (hop == '0) begin
         scan_new = scan_new & ~OCC_MASK;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      home_ff       <= home_in;
      free_idx_ff   <= free_idx_in;
      free_span_ff  <= free_span_in;
      free_word_ff  <= free_word_in;
      scan_idx_ff   <= scan_idx_in;
      scan_dist_ff  <= scan_dist_in;
      move_idx_ff   <= move_idx_in;
      move_span_ff  <= move_span_in;
      hop_zero_ff   <= hop_zero_in;
      aux_word_ff   <= aux_word_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // next state, memory requests and response load
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      home_in       = home_ff;
      free_idx_in   = free_idx_ff;
      free_span_in  = free_span_ff;
      free_word_in  = free_word_ff;
      scan_idx_in   = scan_idx_ff;
      scan_dist_in  = scan_dist_ff;
      move_idx_in   = move_idx_ff;
      move_span_in  = move_span_ff;
      hop_zero_in   = hop_zero_ff;
      aux_word_in   = aux_word_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_we        = 1'b0;
      mem_waddr     = free_idx_ff;
      mem_wdata     = '0;
      mem_raddr     = free_idx_ff;

      // response word taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // zero every bucket after reset
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               home_in = req_hash_value[IDX_W-1:0];
               if (count_ff == TABLE_CNT) begin
                  res_status_in = STATUS_FULL;
                  state_in      = S_DONE;
               end else begin
                  mem_raddr    = req_hash_value[IDX_W-1:0];
                  free_idx_in  = req_hash_value[IDX_W-1:0];
                  free_span_in = '0;
                  state_in     = S_PROBE;
               end
            end
         end
         // walk forward to the nearest free bucket
         S_PROBE: begin
            if (mem_rdata[NEIGHBORHOOD]) begin
               free_idx_in  = free_idx_ff + 1'b1;
               free_span_in = free_span_ff + 1'b1;
               mem_raddr    = free_idx_ff + 1'b1;
            end else begin
               free_word_in = mem_rdata;
               state_in     = S_CHECK;
            end
         end
         // free bucket in reach, or start a displacement scan
         S_CHECK: begin
            if (32'(free_span_ff) >= 32'(NEIGHBORHOOD)) begin
               mem_raddr    = free_idx_ff - IDX_W'(NEIGHBORHOOD - 1);
               scan_idx_in  = free_idx_ff - IDX_W'(NEIGHBORHOOD - 1);
               scan_dist_in = SD_W'(NEIGHBORHOOD - 1);
               state_in     = S_SCAN;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_SCAN: begin
            if (found) begin
               // rewrite the hop bits of the scanned bucket, fetch the entry to move
               mem_we       = 1'b1;
               mem_waddr    = scan_idx_ff;
               mem_wdata    = scan_new;
               aux_word_in  = scan_new;
               hop_zero_in  = (hop == '0);
               move_idx_in  = scan_idx_ff + IDX_W'(hop);
               move_span_in = scan_dist_ff - SD_W'(hop);
               mem_raddr    = scan_idx_ff + IDX_W'(hop);
               state_in     = S_SETFREE;
            end else if (scan_dist_ff == SD_W'(1)) begin
               res_status_in = STATUS_NO_MOVE;
               state_in      = S_DONE;
            end else begin
               scan_idx_in  = scan_idx_ff + 1'b1;
               scan_dist_in = scan_dist_ff - 1'b1;
               mem_raddr    = scan_idx_ff + 1'b1;
            end
         end
         // old free bucket takes the moved entry
         S_SETFREE: begin
            mem_we       = 1'b1;
            mem_waddr    = free_idx_ff;
            mem_wdata    = free_word_ff | OCC_MASK;
            free_word_in = hop_zero_ff ? aux_word_ff : (mem_rdata & ~OCC_MASK);
            free_idx_in  = move_idx_ff;
            free_span_in = free_span_ff - IDX_W'(move_span_ff);
            state_in     = hop_zero_ff ? S_CHECK : S_CLRMOVE;
         end
         // vacated bucket loses its occupied flag
         S_CLRMOVE: begin
            mem_we    = 1'b1;
            mem_waddr = free_idx_ff;
            mem_wdata = free_word_ff;
            state_in  = S_CHECK;
         end
         // occupy the free bucket, fetch home for its hop bit
         S_FINAL: begin
            mem_we    = 1'b1;
            mem_waddr = free_idx_ff;
            mem_wdata = free_word_ff | OCC_MASK;
            mem_raddr = home_ff;
            if (free_span_ff == '0) begin
               mem_wdata     = free_word_ff | OCC_MASK | WORD_W'(1);
               count_in      = count_ff + 1'b1;
               res_status_in = STATUS_OK;
               state_in      = S_DONE;
            end else begin
               state_in = S_HOMEUPD;
            end
         end
         S_HOMEUPD: begin
            mem_we        = 1'b1;
            mem_waddr     = home_ff;
            mem_wdata     = mem_rdata | (WORD_W'(1) << free_span_ff);
            count_in      = count_ff + 1'b1;
            res_status_in = STATUS_OK;
            state_in      = S_DONE;
         end
         // hand the result to the output register
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_occ_in    = OCC_W'(count_ff);
               if (res_status_ff == STATUS_OK) begin
                  rsp_slot_in = SLOT_W'(free_idx_ff);
                  rsp_dist_in = DIST_W'(free_span_ff);
               end else begin
                  rsp_slot_in = '0;
                  rsp_dist_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_hop_distance = rsp_dist_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   // occupancy never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= TABLE_CNT)
      else $error("occupancy count above table size");

   // occupancy only steps up by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> (count_ff == $past(count_ff) + 1'b1))
      else $error("occupancy count changed by other than one");

   // a response word only appears after the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == S_DONE))
      else $error("response raised outside done state");

   // a scan never runs with zero distance
   a_scan_dist: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_dist_ff != '0))
      else $error("displacement scan at zero distance");

   // no bucket write while waiting for a request
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("bucket write while idle");

endmodule

[hdl/hopscotch_hash_insert.sv]
`timescale 1ns / 1ps
// Hopscotch hash insert top level: bucket memory and insert sequencer.
//
//   channel   direction  handshake            word
//   req_      in         req_valid/req_stall  req_hash_value
//   rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_slot_index,
//                                             rsp_hop_distance, rsp_occupancy
//
// One insert at a time. An insert probes forward past occupied buckets, then for each
// displacement scans up to NEIGHBORHOOD-1 buckets and updates the moved buckets, then
// occupies the slot and, unless it is the home bucket, sets the hop bit in the home bucket;
// each step is a single access to the bucket memory. A full table answers with no access.
// After reset the block clears 2**LOG2_BUCKETS buckets, one per cycle, with
// req_stall high. A stalled response is held in the output register while the
// next request is already accepted; that request then waits for the register.
module hopscotch_hash_insert
   import hhi_pkg::*;
#(
   parameter int LOG2_BUCKETS = LOG2_BUCKETS_DEF,
   parameter int NEIGHBORHOOD = NEIGHBORHOOD_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [HASH_W-1:0]   req_hash_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_index,
   output logic [DIST_W-1:0]   rsp_hop_distance,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   logic                    mem_we;
   logic [LOG2_BUCKETS-1:0] mem_waddr;
   logic [NEIGHBORHOOD:0]   mem_wdata;
   logic [LOG2_BUCKETS-1:0] mem_raddr;
   logic [NEIGHBORHOOD:0]   mem_rdata;

   // bucket words: hop bits plus occupied flag
   hhi_bucket_ram #(
      .ADDR_W (LOG2_BUCKETS),
      .DATA_W (NEIGHBORHOOD + 1)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // insert sequencer
   hhi_ctrl #(
      .LOG2_BUCKETS (LOG2_BUCKETS),
      .NEIGHBORHOOD (NEIGHBORHOOD)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_hash_value   (req_hash_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_hop_distance (rsp_hop_distance),
      .rsp_occupancy    (rsp_occupancy),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata)
   );

endmodule

[tb/hopscotch_hash_insert_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the hopscotch hash insert block.
module hopscotch_hash_insert_tb;
   import hhi_pkg::*;

   localparam int          BUCKET_BITS = LOG2_BUCKETS_DEF;
   localparam int          NBH         = NEIGHBORHOOD_DEF;
   localparam int unsigned TBL_SIZE    = 1 << BUCKET_BITS;
   localparam int unsigned TBL_MASK    = TBL_SIZE - 1;
   localparam int unsigned CROWD_HOME  = 512;
   localparam int          RANDOM_ITEMS = 1500;
   // worst legal insert: clearing pass, a full-lap probe and a displacement per bucket
   localparam int          IDLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 64;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [DIST_W-1:0]   hops;
      logic [OCC_W-1:0]    occ;
   } insert_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [HASH_W-1:0]   req_hash_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic [DIST_W-1:0]   rsp_hop_distance;
   logic [OCC_W-1:0]    rsp_occupancy;

   // shadow table: hop bits plus occupied flag at bit NBH
   logic [NBH:0]        bucket_word [TBL_SIZE];
   int unsigned         occupied_count = 0;
   insert_result_type   pending_results [$];

   int                  error_count = 0;
   int                  burst_left = 0;
   int                  idle_cycles = 0;
   int                  stall_mode = 0;
   int                  stall_left = 0;

   hopscotch_hash_insert dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_hash_value   (req_hash_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_hop_distance (rsp_hop_distance),
      .rsp_occupancy    (rsp_occupancy)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Insert one hash into the shadow table and return the word the block should send.
   function automatic insert_result_type predict_insert(input logic [HASH_W-1:0] hash);
      int unsigned       home;
      int unsigned       free_idx;
      int unsigned       free_span;
      int unsigned       scan_dist;
      int unsigned       scan_idx;
      int unsigned       hop;
      int unsigned       move_span;
      insert_result_type res;
      home      = hash & TBL_MASK;
      free_idx  = home;
      free_span = 0;
      res.status = STATUS_OK;
      res.slot   = '0;
      res.hops   = '0;
      res.occ    = OCC_W'(occupied_count);
      // linear probe for the nearest free bucket
      while (free_span < TBL_SIZE && bucket_word[free_idx][NBH]) begin
         free_span++;
         free_idx = (free_idx + 1) & TBL_MASK;
      end
      if (free_span >= TBL_SIZE) begin
         res.status = STATUS_FULL;
         return res;
      end
      // pull the free bucket back into the neighborhood
      while (free_span > NBH - 1) begin
         scan_dist = NBH - 1;
         scan_idx  = (free_idx - scan_dist) & TBL_MASK;
         forever begin
            hop = NBH;
            for (int d = NBH - 1; d >= 0; d--)
               if (bucket_word[scan_idx][d]) hop = d;
            if (hop < scan_dist) break;
            scan_dist--;
            scan_idx = (scan_idx + 1) & TBL_MASK;
            if (scan_dist == 0) begin
               res.status = STATUS_NO_MOVE;
               return res;
            end
         end
         move_span = scan_dist - hop;
         bucket_word[(scan_idx + hop) & TBL_MASK][NBH] = 1'b0;
         bucket_word[free_idx][NBH] = 1'b1;
         bucket_word[scan_idx][hop] = 1'b0;
         bucket_word[scan_idx][scan_dist] = 1'b1;
         free_span -= move_span;
         free_idx  = (free_idx - move_span) & TBL_MASK;
      end
      bucket_word[free_idx][NBH] = 1'b1;
      bucket_word[home][free_span] = 1'b1;
      occupied_count++;
      res.slot = SLOT_W'(free_idx);
      res.hops = DIST_W'(free_span);
      res.occ  = OCC_W'(occupied_count);
      return res;
   endfunction

   // Send one hash word; the sender runs in bursts with random gaps between them.
   task automatic send_hash(input logic [HASH_W-1:0] hash);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 30);
      end
      burst_left--;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_hash_value <= hash;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_insert(hash));
   endtask

   // Random upper bits, chosen home bucket.
   task automatic send_home(input int unsigned home);
      logic [HASH_W-1:0] hash;
      hash = $urandom();
      hash[BUCKET_BITS-1:0] = home[BUCKET_BITS-1:0];
      send_hash(hash);
   endtask

   // Field extremes and wraparound at the table end.
   task automatic test_corner_hashes();
      send_hash(32'h0000_0000);
      send_hash(32'hFFFF_FFFF);
      send_hash(32'hFFFF_FC00);
      send_hash(32'h0000_03FF);
   endtask

   // A full neighborhood on one home, then one more: nothing can be displaced.
   task automatic test_crowded_home();
      for (int n = 0; n < NBH + 1; n++) send_home(CROWD_HOME);
   endtask

   // Farthest direct hop, then an insert that needs one entry moved forward.
   task automatic test_forced_displacement();
      send_home(CROWD_HOME + 1);
      send_home(CROWD_HOME + NBH + 1);
      send_home(CROWD_HOME + 2);
   endtask

   // Mostly clustered homes to force long probes and displacements, plus uniform noise.
   task automatic test_random_inserts(input int count);
      logic [HASH_W-1:0] hash;
      int unsigned       cluster_base;
      int                pick;
      cluster_base = $urandom_range(0, TBL_SIZE - 1);
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) cluster_base = $urandom_range(0, TBL_SIZE - 1);
         hash = $urandom();
         pick = $urandom_range(0, 99);
         if (pick < 55)
            hash[BUCKET_BITS-1:0] =
               BUCKET_BITS'((cluster_base + $urandom_range(0, 40)) & TBL_MASK);
         else if (pick < 65)
            hash[HASH_W-1:BUCKET_BITS] = pick[0] ? '1 : '0;
         send_hash(hash);
      end
   endtask

   // Fill every free bucket at its own home, then insert into the full table.
   task automatic test_full_table();
      for (int unsigned b = 0; b < TBL_SIZE; b++)
         if (!bucket_word[b][NBH]) send_home(b);
      for (int n = 0; n < 6; n++) send_hash($urandom());
   endtask

   // Receiver stall pattern: phases of no stall, light stall and heavy stall.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 9) < 8);
         end
      endcase
   end

   // Compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      insert_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            if (error_count < 10)
               $display("%0t: result with none pending: status %0d slot %0d dist %0d occ %0d",
                        $realtime, rsp_status, rsp_slot_index, rsp_hop_distance,
                        rsp_occupancy);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_status !== exp_res.status || rsp_slot_index !== exp_res.slot ||
                rsp_hop_distance !== exp_res.hops || rsp_occupancy !== exp_res.occ) begin
               if (error_count < 10)
                  $display("%0t: mismatch exp st %0d sl %0d d %0d occ %0d, ",
                           $realtime, exp_res.status, exp_res.slot, exp_res.hops,
                           exp_res.occ, "got st %0d sl %0d d %0d occ %0d",
                           rsp_status, rsp_slot_index, rsp_hop_distance,
                           rsp_occupancy);
               error_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** hopscotch_hash_insert: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int b = 0; b < TBL_SIZE; b++) bucket_word[b] = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_corner_hashes();
      test_crowded_home();
      test_forced_displacement();
      test_random_inserts(RANDOM_ITEMS);
      test_full_table();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_results.size() == 0)
         $display("** hopscotch_hash_insert: PASSED **");
      else
         $display("** hopscotch_hash_insert: FAILED **");
      $finish;
   end

endmodule
